>>> hdl/clock_mult_shift_calc_top_macros.svh
`ifndef CLOCK_MULT_SHIFT_CALC_TOP_MACROS_SVH
`define CLOCK_MULT_SHIFT_CALC_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CMSC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cmsc: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CMSC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cmsc: assertion failed");

`endif

>>> hdl/cmsc_pkg.sv
package cmsc_pkg;

	localparam int DATA_W    = 32;
	localparam int WIDE_W    = 2 * DATA_W;
	localparam int SHIFT_W   = 6;
	localparam int PC_W      = 4;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_CNT_W = 6;

	localparam logic [SHIFT_W-1:0]   SHIFT_MAX    = 6'd32;
	localparam logic [SHIFT_W-1:0]   SHIFT_MIN    = 6'd1;
	localparam logic [SHIFT_W-1:0]   SHIFT_NONE   = 6'd0;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST     = 6'd63;
	localparam logic [DATA_W-1:0]    TARGET_RESET = 32'd1000000000;
	localparam logic [DATA_W-1:0]    SPAN_RESET   = 32'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_RATE = 1'b0,
		REG_MAX_SECONDS = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_MUL,
		OP_CLZ_INIT,
		OP_CLZ_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DEC_SHIFT,
		OP_OUT_OK,
		OP_OUT_NOFIT,
		OP_OUT_ERR
	} op_t;

	typedef enum logic [3:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_NO_INPUT,
		CND_SRC_ZERO,
		CND_CLZ_BUSY,
		CND_DIV_BUSY,
		CND_FITS,
		CND_LAST_SHIFT,
		CND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic init;
		logic step;
	} div_ctl_t;

	typedef struct packed {
		logic last;
	} div_sts_t;

	// program addresses that are jump targets, and PC_CHK_ZERO, the step after accept
	localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
	localparam logic [PC_W-1:0] PC_CHK_ZERO  = 4'd1;
	localparam logic [PC_W-1:0] PC_CLZ       = 4'd4;
	localparam logic [PC_W-1:0] PC_TRIAL     = 4'd5;
	localparam logic [PC_W-1:0] PC_DIV       = 4'd6;
	localparam logic [PC_W-1:0] PC_WAIT_OK   = 4'd10;
	localparam logic [PC_W-1:0] PC_WAIT_NFIT = 4'd12;
	localparam logic [PC_W-1:0] PC_WAIT_ERR  = 4'd14;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			4'd0:  w = '{OP_ACCEPT,    CND_NO_INPUT,   PC_IDLE};
			4'd1:  w = '{OP_NONE,      CND_SRC_ZERO,   PC_WAIT_ERR};
			4'd2:  w = '{OP_MUL,       CND_NEVER,      PC_IDLE};
			4'd3:  w = '{OP_CLZ_INIT,  CND_NEVER,      PC_IDLE};
			4'd4:  w = '{OP_CLZ_STEP,  CND_CLZ_BUSY,   PC_CLZ};
			4'd5:  w = '{OP_DIV_INIT,  CND_NEVER,      PC_IDLE};
			4'd6:  w = '{OP_DIV_STEP,  CND_DIV_BUSY,   PC_DIV};
			4'd7:  w = '{OP_NONE,      CND_FITS,       PC_WAIT_OK};
			4'd8:  w = '{OP_NONE,      CND_LAST_SHIFT, PC_WAIT_NFIT};
			4'd9:  w = '{OP_DEC_SHIFT, CND_ALWAYS,     PC_TRIAL};
			4'd10: w = '{OP_NONE,      CND_OUT_BUSY,   PC_WAIT_OK};
			4'd11: w = '{OP_OUT_OK,    CND_ALWAYS,     PC_IDLE};
			4'd12: w = '{OP_NONE,      CND_OUT_BUSY,   PC_WAIT_NFIT};
			4'd13: w = '{OP_OUT_NOFIT, CND_ALWAYS,     PC_IDLE};
			4'd14: w = '{OP_NONE,      CND_OUT_BUSY,   PC_WAIT_ERR};
			4'd15: w = '{OP_OUT_ERR,   CND_ALWAYS,     PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> hdl/cmsc_in_if.sv
interface cmsc_in_if;
	import cmsc_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] source_rate;

	modport source (output valid, output source_rate, input ready);
	modport sink   (input valid, input source_rate, output ready);
endinterface

>>> hdl/cmsc_out_if.sv
interface cmsc_out_if;
	import cmsc_pkg::*;

	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  multiplier;
	logic [SHIFT_W-1:0] shift_amount;
	logic               rate_error;

	modport source (output valid, output multiplier, output shift_amount, output rate_error,
		input ready);
	modport sink   (input valid, input multiplier, input shift_amount, input rate_error,
		output ready);
endinterface

>>> hdl/cmsc_div.sv
module cmsc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmsc_pkg::div_ctl_t             ctl,
	input  logic [cmsc_pkg::WIDE_W-1:0]    dividend,
	input  logic [cmsc_pkg::DATA_W-1:0]    divisor,
	output logic [cmsc_pkg::WIDE_W-1:0]    quotient,
	output cmsc_pkg::div_sts_t             sts
);
	import cmsc_pkg::*;

	// restoring divider, one quotient bit per cycle while step is held, msb first
	logic [WIDE_W-1:0]    num_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W:0]      trial;
	logic [DATA_W:0]      diff;
	logic                 take;

	assign trial = {rem_q, num_q[WIDE_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign take  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.init) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (ctl.step) begin
			num_q <= {num_q[WIDE_W-2:0], take};
			rem_q <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
		end
	end

	assign quotient = num_q;
	assign sts.last = (cnt_q == DIV_LAST);
endmodule

>>> hdl/clock_mult_shift_calc_top.sv
// a leading zero count of 0..32 steps precedes 1..32 division trials
// the sequencer holds a finished result while the output still waits for ready
// throughput: one transaction at a time, next source_rate taken once the previous result is
// registered; each trial is a 64-step pass of the one-bit-per-cycle serial divider
// a zero source_rate answers with rate_error set, without a division
// reset: arst_n asynchronous, active low; target_rate 1000000000, max_seconds 10, no result held
module clock_mult_shift_calc_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cmsc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [cmsc_pkg::DATA_W-1:0]      cfg_data,
	cmsc_in_if.sink                          in_ch,
	cmsc_out_if.source                       out_ch
);
	import cmsc_pkg::*;

	`include "clock_mult_shift_calc_top_macros.svh"

	logic [DATA_W-1:0]    target_q;
	logic [DATA_W-1:0]    span_q;
	logic [DATA_W-1:0]    src_q;
	logic [WIDE_W-1:0]    prod_q;
	logic [DATA_W-1:0]    clz_q;
	logic [SHIFT_W-1:0]   limit_q;
	logic [SHIFT_W-1:0]   shift_q;
	logic [PC_W-1:0]      pc_q;
	logic                 out_valid_q;
	logic [DATA_W-1:0]    mult_q;
	logic [SHIFT_W-1:0]   out_shift_q;
	logic                 err_q;

	ucode_t            uw;
	logic              take_jump;
	logic              clz_busy;
	logic              fits;
	logic [WIDE_W-1:0] dividend;
	logic [WIDE_W-1:0] quot;
	logic [WIDE_W-1:0] span_w;
	logic [WIDE_W-1:0] src_w;
	div_ctl_t          div_ctl;
	div_sts_t          div_sts;

	assign uw = ucode_rom(pc_q);

	assign span_w   = {{DATA_W{1'b0}}, span_q};
	assign src_w    = {{DATA_W{1'b0}}, src_q};
	assign clz_busy = !clz_q[DATA_W-1] && (limit_q != SHIFT_MAX);
	assign fits     = ((quot >> limit_q) == '0);
	assign dividend = ({{DATA_W{1'b0}}, target_q} << shift_q)
		+ {{(DATA_W+1){1'b0}}, src_q[DATA_W-1:1]};

	assign div_ctl.init = (uw.op == OP_DIV_INIT);
	assign div_ctl.step = (uw.op == OP_DIV_STEP);

	cmsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (dividend),
		.divisor  (src_q),
		.quotient (quot),
		.sts      (div_sts)
	);

	always_comb begin
		unique case (uw.cond)
			CND_NEVER:      take_jump = 1'b0;
			CND_ALWAYS:     take_jump = 1'b1;
			CND_NO_INPUT:   take_jump = !in_ch.valid;
			CND_SRC_ZERO:   take_jump = (src_q == '0);
			CND_CLZ_BUSY:   take_jump = clz_busy;
			CND_DIV_BUSY:   take_jump = !div_sts.last;
			CND_FITS:       take_jump = fits;
			CND_LAST_SHIFT: take_jump = (shift_q == SHIFT_MIN);
			CND_OUT_BUSY:   take_jump = out_valid_q && !out_ch.ready;
			default:        take_jump = 1'b0;
		endcase
	end

	assign in_ch.ready = (uw.op == OP_ACCEPT);

	// sequencer, output handshake and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			out_valid_q <= 1'b0;
			target_q    <= TARGET_RESET;
			span_q      <= SPAN_RESET;
		end else begin
			pc_q <= take_jump ? uw.target : pc_q + 1'b1;
			if (uw.op == OP_OUT_OK || uw.op == OP_OUT_NOFIT || uw.op == OP_OUT_ERR) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_TARGET_RATE: target_q <= cfg_data;
					REG_MAX_SECONDS: span_q   <= cfg_data;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_ACCEPT: begin
				if (in_ch.valid) begin
					src_q <= in_ch.source_rate;
				end
			end
			OP_MUL: begin
				prod_q <= span_w * src_w;
			end
			OP_CLZ_INIT: begin
				clz_q   <= prod_q[WIDE_W-1:DATA_W];
				limit_q <= '0;
				shift_q <= SHIFT_MAX;
			end
			OP_CLZ_STEP: begin
				// leading zero count of the upper product word gives the limit
				if (clz_busy) begin
					clz_q   <= {clz_q[DATA_W-2:0], 1'b0};
					limit_q <= limit_q + 1'b1;
				end
			end
			OP_DEC_SHIFT: begin
				shift_q <= shift_q - 1'b1;
			end
			OP_OUT_OK: begin
				mult_q      <= quot[DATA_W-1:0];
				out_shift_q <= shift_q;
				err_q       <= 1'b0;
			end
			OP_OUT_NOFIT: begin
				mult_q      <= quot[DATA_W-1:0];
				out_shift_q <= SHIFT_NONE;
				err_q       <= 1'b0;
			end
			OP_OUT_ERR: begin
				mult_q      <= '0;
				out_shift_q <= SHIFT_NONE;
				err_q       <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.multiplier   = mult_q;
	assign out_ch.shift_amount = out_shift_q;
	assign out_ch.rate_error   = err_q;

	`CMSC_ASSERT_IMP(a_err_zero, out_ch.valid && out_ch.rate_error, (out_ch.multiplier == '0) && (out_ch.shift_amount == SHIFT_NONE))
	`CMSC_ASSERT_IMP(a_shift_range, out_ch.valid, out_ch.shift_amount <= SHIFT_MAX)
	`CMSC_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.multiplier) && $stable(out_ch.shift_amount))
	`CMSC_ASSERT_NXT(a_accept_seq, in_ch.valid && in_ch.ready, pc_q == PC_CHK_ZERO)
	`CMSC_ASSERT_IMP(a_trial_shift, uw.op == OP_DIV_INIT, (shift_q >= SHIFT_MIN) && (shift_q <= SHIFT_MAX) && (limit_q <= SHIFT_MAX))
endmodule

>>> tb/clock_mult_shift_calc_top_tb.sv
`timescale 1ns / 100ps

module clock_mult_shift_calc_top_tb;
	import cmsc_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 5000;
	localparam int RAND_PHASES = 6;
	localparam int RAND_ITEMS  = 41;

	typedef struct packed {
		logic [DATA_W-1:0]  multiplier;
		logic [SHIFT_W-1:0] shift_amount;
		logic               rate_error;
	} conv_pair_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [DATA_W-1:0]    cfg_data;

	cmsc_in_if  in_ch ();
	cmsc_out_if out_ch ();

	clock_mult_shift_calc_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// shadow copy of the block's registers
	logic [DATA_W-1:0] target_cfg;
	logic [DATA_W-1:0] span_cfg;

	logic [DATA_W-1:0] rate_queue[$];
	conv_pair_t        pending_pairs[$];

	int n_errors  = 0;
	int n_sent    = 0;
	int n_results = 0;
	int n_cycles  = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	function automatic conv_pair_t calc_pair(input logic [DATA_W-1:0] tgt,
		input logic [DATA_W-1:0] span, input logic [DATA_W-1:0] src);
		conv_pair_t        r;
		logic [WIDE_W-1:0] hi;
		logic [WIDE_W-1:0] q;
		int                nbits;
		int                lim;
		int                s;
		r = '0;
		if (src == '0) begin
			r.rate_error = 1'b1;
			return r;
		end
		hi = ({32'b0, span} * {32'b0, src}) >> DATA_W;
		nbits = 0;
		while (hi != '0) begin
			hi = hi >> 1;
			nbits++;
		end
		lim = DATA_W - nbits;
		q = '0;
		// widest shift first, first one that fits under the limit wins
		for (s = 32; s > 0; s--) begin
			q = ({32'b0, tgt} << s) + {33'b0, src[DATA_W-1:1]};
			q = q / {32'b0, src};
			if ((q >> lim) == '0)
				break;
		end
		r.multiplier   = q[DATA_W-1:0];
		r.shift_amount = s[SHIFT_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (want !== got) begin
			n_errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		if (idx == REG_TARGET_RATE)
			target_cfg = val;
		else
			span_cfg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		while (rate_queue.size() != 0 || in_ch.valid || pending_pairs.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: presents queued source rates, predicts on each accepted transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid       <= 1'b0;
			in_ch.source_rate <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				pending_pairs.push_back(calc_pair(target_cfg, span_cfg, in_ch.source_rate));
				n_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (rate_queue.size() != 0 &&
					((n_sent >= 40 && n_sent < 80) || $urandom_range(99) >= 35)) begin
					in_ch.valid       <= 1'b1;
					in_ch.source_rate <= rate_queue.pop_front();
				end else begin
					in_ch.valid       <= 1'b0;
					in_ch.source_rate <= $urandom;
				end
			end
		end
	end

	// monitor: checks each result against the oldest prediction, drives ready
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_results++;
				if (pending_pairs.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected result: expected none, actual mult %0d shift %0d err %0d",
						$time, out_ch.multiplier, out_ch.shift_amount, out_ch.rate_error);
				end else begin
					conv_pair_t want;
					want = pending_pairs.pop_front();
					check_field("multiplier", want.multiplier, out_ch.multiplier);
					check_field("shift_amount", DATA_W'(want.shift_amount),
						DATA_W'(out_ch.shift_amount));
					check_field("rate_error", DATA_W'(want.rate_error),
						DATA_W'(out_ch.rate_error));
				end
			end
			// one long hold-off so the block fills and stalls its input
			if (hold_left > 0)
				hold_left--;
			else if (!hold_done && n_results >= 30) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			out_ch.ready <= (hold_left == 0) &&
				((n_results >= 40 && n_results < 80) || $urandom_range(99) >= 35);
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [DATA_W-1:0] dir_rates[$];
		logic [DATA_W-1:0] tgt_set[RAND_PHASES];
		logic [DATA_W-1:0] span_set[RAND_PHASES];
		logic [DATA_W-1:0] r;
		int                p;
		int                k;
		int                sel;

		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_idx    <= REG_TARGET_RATE;
		cfg_data   <= '0;
		target_cfg = TARGET_RESET;
		span_cfg   = SPAN_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero rate, tiny, odd, typical and top-end rates
		@(negedge clk);
		dir_rates = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd32768, 32'd19200000, 32'd24000000,
			32'd1000000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h55555555,
			32'hAAAAAAAA};
		foreach (dir_rates[i]) rate_queue.push_back(dir_rates[i]);
		wait_drain();

		// both registers at full scale: no shift fits for the fastest rates
		write_reg(REG_TARGET_RATE, 32'hFFFFFFFF);
		write_reg(REG_MAX_SECONDS, 32'hFFFFFFFF);
		@(negedge clk);
		dir_rates = '{32'hFFFFFFFF, 32'h80000000, 32'd1, 32'd0, 32'd1000};
		foreach (dir_rates[i]) rate_queue.push_back(dir_rates[i]);
		wait_drain();

		// zero target gives a zero multiplier at the widest shift
		write_reg(REG_TARGET_RATE, 32'd0);
		write_reg(REG_MAX_SECONDS, 32'd0);
		@(negedge clk);
		dir_rates = '{32'd1, 32'hFFFFFFFF, 32'd0};
		foreach (dir_rates[i]) rate_queue.push_back(dir_rates[i]);
		wait_drain();

		write_reg(REG_TARGET_RATE, 32'd1);
		write_reg(REG_MAX_SECONDS, 32'd10);
		@(negedge clk);
		dir_rates = '{32'd1, 32'd2, 32'd3, 32'hFFFFFFFF};
		foreach (dir_rates[i]) rate_queue.push_back(dir_rates[i]);
		wait_drain();

		tgt_set  = '{TARGET_RESET, 32'hFFFFFFFF, 32'd1, 32'd1000000, $urandom, $urandom};
		span_set = '{SPAN_RESET, 32'd0, 32'hFFFFFFFF, 32'd600, $urandom, $urandom_range(3600, 1)};
		for (p = 0; p < RAND_PHASES; p++) begin
			write_reg(REG_TARGET_RATE, tgt_set[p]);
			write_reg(REG_MAX_SECONDS, span_set[p]);
			@(negedge clk);
			for (k = 0; k < RAND_ITEMS; k++) begin
				sel = $urandom_range(99);
				if (sel < 3)
					r = '0;
				else if (sel < 35)
					r = $urandom;
				else if (sel < 60)
					r = $urandom_range(1000000000, 1000000);
				else if (sel < 75)
					r = $urandom_range(1000, 1);
				else if (sel < 85)
					r = 32'd1 << $urandom_range(31);
				else
					r = $urandom_range(32'hFFFFFFFF, 32'hF0000000);
				rate_queue.push_back(r);
			end
			wait_drain();
		end

		repeat (50) @(posedge clk);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
